/* sv/updraft_field_max_lift_defines.svh */
// Assertion macros for the updraft field block
`ifndef UPDRAFT_FIELD_MAX_LIFT_DEFINES_SVH
`define UPDRAFT_FIELD_MAX_LIFT_DEFINES_SVH
`ifndef SYNTHESIS
// check a property on every clock edge out of reset
`define UFML_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ufml: property failed");
// check that a trigger is followed by a property in the next cycle
`define UFML_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error("ufml: sequence failed");
`else
`define UFML_ASSERT(label, prop)
`define UFML_ASSERT_NEXT(label, trig, prop)
`endif
`endif

/* sv/ufml_pkg.sv */
// Shared types, constants and fixed-point tables of the updraft field block
package ufml_pkg;

  // request codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // fixed-point constants
  localparam longint          Q30        = 64'sd1 << 30;
  localparam longint          PI_Q30     = 64'sd3373259426;
  localparam logic [30:0]     EXP_ONE    = 31'h4000_0000;
  localparam logic [29:0]     HALF_Q30   = 30'h2000_0000;
  localparam logic [10:0]     WEAK_LIMIT = 11'd10;
  localparam logic [8:0]      HEADING_WRAP = 9'd360;
  localparam logic [30:0]     RSQ_MIN    = 31'd100;
  localparam logic [22:0]     DRIFT_HALF = 23'd5000000;
  // 1e7 = 2^7 * 78125; the odd part goes through a reciprocal multiply
  localparam logic [16:0]     DRIFT_DIV  = 17'd78125;
  localparam logic [35:0]     RECIP_M    = 36'((64'd1 << 52) / 64'd78125);
  localparam int              DIV_STEPS  = 20;
  localparam int              PIPE_LAT   = 40;

  // one table entry
  typedef struct packed {
    logic signed [20:0] north_dm;
    logic signed [20:0] east_dm;
    logic [10:0]        strength_cms;
    logic [11:0]        radius_along_m;
    logic [11:0]        radius_across_m;
    logic [8:0]         heading_deg;
    logic               drifts;
    logic [31:0]        created_us;
  } entry_t;

  // query operands, held for the whole sweep
  typedef struct packed {
    logic signed [20:0] north_dm;
    logic signed [20:0] east_dm;
    logic [31:0]        time_us;
    logic signed [13:0] wind_north_cms;
    logic signed [13:0] wind_east_cms;
  } query_t;

  // one lane of the bit-serial exponent divider
  typedef struct packed {
    logic [30:0] rem;
    logic [30:0] den;
    logic [3:0]  low;
    logic [19:0] quo;
  } div_lane_t;

  typedef logic [14:0] sin_tab_t [91];
  typedef logic [30:0] exp_k_tab_t [64];
  typedef logic [30:0] exp_i_tab_t [16];

  // signed quotient truncated toward zero, by shift and subtract
  function automatic longint div_trunc(longint num, longint den);
    longint unsigned a;
    longint unsigned b;
    longint unsigned q;
    longint unsigned r;
    a = (num < 0) ? -num : num;
    b = (den < 0) ? -den : den;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
  endfunction

  // exp(-x) in Q30 by a truncated Taylor series
  function automatic longint exp_neg_q30(longint x);
    longint sum;
    longint term;
    sum  = Q30;
    term = Q30;
    for (int n = 1; n <= 16; n++) begin
      term = -div_trunc(div_trunc(term * x, Q30), longint'(n));
      sum  = sum + term;
    end
    return sum;
  endfunction

  // sin(k deg) in Q14, k = 0..90
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    longint   x;
    longint   sum;
    longint   term;
    for (int k = 0; k <= 90; k++) begin
      x    = div_trunc(longint'(k) * PI_Q30, 64'sd180);
      sum  = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
        term = -div_trunc(div_trunc(div_trunc(term * x, Q30) * x, Q30),
                          longint'((2 * n) * (2 * n + 1)));
        sum  = sum + term;
      end
      if (sum < 0) sum = 0;
      t[k] = 15'((sum + 64'sd32768) >>> 16);
    end
    return t;
  endfunction

  // exp(-k/64) in Q30
  function automatic exp_k_tab_t build_exp_k_tab();
    exp_k_tab_t t;
    for (int k = 0; k < 64; k++) begin
      t[k] = 31'(exp_neg_q30(longint'(k) <<< 24));
    end
    return t;
  endfunction

  // exp(-i) in Q30, by repeated rounded products
  function automatic exp_i_tab_t build_exp_i_tab();
    exp_i_tab_t        t;
    longint unsigned   v;
    longint unsigned   e1;
    e1   = longint'(exp_neg_q30(Q30));
    t[0] = EXP_ONE;
    t[1] = 31'(e1);
    v    = e1;
    for (int k = 2; k < 16; k++) begin
      v    = (v * e1 + (64'd1 << 29)) >> 30;
      t[k] = 31'(v);
    end
    return t;
  endfunction

  localparam sin_tab_t   SIN_TAB = build_sin_tab();
  localparam exp_k_tab_t EXP_K   = build_exp_k_tab();
  localparam exp_i_tab_t EXP_I   = build_exp_i_tab();

endpackage

/* sv/ufml_table.sv */
// Updraft table memory: one write port, one registered read port
module ufml_table #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  ufml_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic              rd_valid,
  output ufml_pkg::entry_t  rd_data
);
  import ufml_pkg::*;

  entry_t mem [DEPTH];
  entry_t rd_data_r;
  logic   rd_valid_r;

  // storage write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // read strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_data  = rd_data_r;

endmodule

/* sv/ufml_div_step.sv */
// One restoring step of the exponent divider, registered
module ufml_div_step (
  input  logic                 clk,
  input  ufml_pkg::div_lane_t  in_lane,
  output ufml_pkg::div_lane_t  out_lane
);
  import ufml_pkg::*;

  div_lane_t   lane_r;
  div_lane_t   lane_nxt;
  logic [31:0] trial;
  logic        take;

  // shift in the next dividend bit, subtract where it fits
  always_comb begin
    trial             = {in_lane.rem, in_lane.low[3]};
    take              = trial >= {1'b0, in_lane.den};
    lane_nxt.den      = in_lane.den;
    lane_nxt.low      = {in_lane.low[2:0], 1'b0};
    lane_nxt.quo      = {in_lane.quo[18:0], take};
    lane_nxt.rem      = take ? 31'(trial - {1'b0, in_lane.den}) : trial[30:0];
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign out_lane = lane_r;

endmodule

/* sv/ufml_lift_pipe.sv */
// Per-entry lift datapath: drift, rotation, exponent division, exp and scale
module ufml_lift_pipe (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ufml_pkg::entry_t  in_entry,
  input  ufml_pkg::query_t  query,
  output logic              out_valid,
  output logic [10:0]       out_lift
);
  import ufml_pkg::*;

  // shape data carried down the pipe
  typedef struct packed {
    logic signed [15:0] sin_q14;
    logic signed [15:0] cos_q14;
    logic [30:0]        rsq_u;
    logic [30:0]        rsq_v;
    logic [10:0]        strength;
    logic               zero;
  } shape_t;

  function automatic logic [13:0] abs14(logic signed [13:0] w);
    return w[13] ? 14'(-w) : 14'(w);
  endfunction

  function automatic logic [25:0] round_mag(logic signed [42:0] v);
    logic [42:0] a;
    a = v[42] ? 43'(-v) : 43'(v);
    return 26'((a + 43'd8192) >> 14);
  endfunction

  logic [PIPE_LAT-1:0] vld_r;

  // stage 1 registers
  logic signed [20:0] s1_pos_r [2];
  logic               s1_drift_r;
  logic [10:0]        s1_str_r;
  logic [31:0]        s1_age_r;
  logic [6:0]         s1_si_r, s1_ci_r;
  logic               s1_sn_r, s1_cn_r;
  logic [23:0]        s1_r2_r [2];
  // stage 2..7 drift lanes
  logic signed [20:0] s2_pos_r [2], s3_pos_r [2], s4_pos_r [2];
  logic signed [20:0] s5_pos_r [2], s6_pos_r [2], s7_pos_r [2];
  logic               s2_neg_r [2], s3_neg_r [2], s4_neg_r [2];
  logic               s5_neg_r [2], s6_neg_r [2];
  logic               s2_drift_r, s3_drift_r, s4_drift_r, s5_drift_r, s6_drift_r;
  logic [45:0]        s2_mag_r [2];
  logic [38:0]        s3_y_r [2], s4_y_r [2], s5_y_r [2], s6_y_r [2];
  logic [54:0]        s4_pph_r [2];
  logic [55:0]        s4_ppl_r [2];
  logic [22:0]        s5_q_r [2], s6_q_r [2];
  logic [39:0]        s6_prod_r [2];
  logic signed [23:0] s7_off_r [2];
  shape_t             s2_sh_r, s3_sh_r, s4_sh_r, s5_sh_r, s6_sh_r, s7_sh_r;
  shape_t             s8_sh_r, s9_sh_r, s10_sh_r, s11_sh_r, s12_sh_r, s13_sh_r;
  shape_t             s13_sh_nxt;
  // stage 8..13 rotation and squares
  logic signed [25:0] s8_d_r [2];
  logic signed [41:0] s9_dnc_r, s9_des_r, s9_dns_r, s9_dec_r;
  logic signed [42:0] s10_du_r, s10_dv_r;
  logic [25:0]        s11_mag_r [2];
  logic [51:0]        s12_sq_r [2];
  div_lane_t          s13_lane_r [2];
  // divider chain
  div_lane_t          dl [DIV_STEPS+1][2];
  logic [10:0]        dv_str_r [DIV_STEPS];
  logic               dv_zero_r [DIV_STEPS];
  // tail
  logic [20:0]        se_e_r;
  logic [10:0]        se_str_r, m1_str_r, m2_str_r, m3_str_r, m4_str_r;
  logic               se_zero_r, m1_zero_r, m2_zero_r, m3_zero_r, m4_zero_r, m5_zero_r;
  logic [61:0]        m1_prod_r;
  logic [30:0]        m1_p_r, m2_p_r;
  logic [30:0]        m2_m_r;
  logic [61:0]        m3_prod_r;
  logic [30:0]        m4_m_r;
  logic [41:0]        m5_prod_r;
  logic [10:0]        m6_lift_r;

  logic [13:0]        wabs [2];
  logic               wneg [2];
  logic signed [20:0] qpos [2];
  logic [8:0]         hdg;
  logic [8:0]         si_w, ci_w;
  logic               sn_w, cn_w;
  logic [19:0]        rr;
  logic [9:0]         efrac;

  always_comb begin
    wabs[0] = abs14(query.wind_north_cms);
    wabs[1] = abs14(query.wind_east_cms);
    wneg[0] = query.wind_north_cms[13];
    wneg[1] = query.wind_east_cms[13];
    qpos[0] = query.north_dm;
    qpos[1] = query.east_dm;
  end

  // heading into a quarter-wave table index and signs
  always_comb begin
    hdg = (in_entry.heading_deg >= HEADING_WRAP) ? in_entry.heading_deg - HEADING_WRAP
                                                 : in_entry.heading_deg;
    si_w = hdg;
    ci_w = 9'd90 - hdg;
    sn_w = 1'b0;
    cn_w = 1'b0;
    if (hdg > 9'd270) begin
      si_w = 9'd360 - hdg;
      sn_w = 1'b1;
      ci_w = hdg - 9'd270;
    end else if (hdg > 9'd180) begin
      si_w = hdg - 9'd180;
      sn_w = 1'b1;
      ci_w = 9'd270 - hdg;
      cn_w = 1'b1;
    end else if (hdg > 9'd90) begin
      si_w = 9'd180 - hdg;
      ci_w = hdg - 9'd90;
      cn_w = 1'b1;
    end
  end

  // valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_valid};
    end
  end

  // stage 1: age, table indices, squared radii
  always_ff @(posedge clk) begin
    s1_pos_r[0] <= in_entry.north_dm;
    s1_pos_r[1] <= in_entry.east_dm;
    s1_drift_r  <= in_entry.drifts;
    s1_str_r    <= in_entry.strength_cms;
    s1_age_r    <= query.time_us - in_entry.created_us;
    s1_si_r     <= si_w[6:0];
    s1_ci_r     <= ci_w[6:0];
    s1_sn_r     <= sn_w;
    s1_cn_r     <= cn_w;
    s1_r2_r[0]  <= 24'(in_entry.radius_along_m) * 24'(in_entry.radius_along_m);
    s1_r2_r[1]  <= 24'(in_entry.radius_across_m) * 24'(in_entry.radius_across_m);
  end

  // stage 2: wind times age, sine and cosine, radius squared in dm^2
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      s2_mag_r[l] <= 46'(wabs[l]) * 46'(s1_age_r);
      s2_neg_r[l] <= wneg[l];
      s2_pos_r[l] <= s1_pos_r[l];
    end
    s2_drift_r       <= s1_drift_r;
    s2_sh_r.sin_q14  <= s1_sn_r ? -16'(SIN_TAB[s1_si_r]) : 16'(SIN_TAB[s1_si_r]);
    s2_sh_r.cos_q14  <= s1_cn_r ? -16'(SIN_TAB[s1_ci_r]) : 16'(SIN_TAB[s1_ci_r]);
    s2_sh_r.rsq_u    <= (s1_r2_r[0] == '0) ? RSQ_MIN :
                        31'({s1_r2_r[0], 6'b0}) + 31'({s1_r2_r[0], 5'b0}) +
                        31'({s1_r2_r[0], 2'b0});
    s2_sh_r.rsq_v    <= (s1_r2_r[1] == '0) ? RSQ_MIN :
                        31'({s1_r2_r[1], 6'b0}) + 31'({s1_r2_r[1], 5'b0}) +
                        31'({s1_r2_r[1], 2'b0});
    s2_sh_r.strength <= s1_str_r;
    s2_sh_r.zero     <= s1_str_r < WEAK_LIMIT;
  end

  // stages 3..7: rounded divide of the drift by 1e7
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      // round half up, then strip the power of two
      s3_y_r[l]    <= 39'((s2_mag_r[l] + 46'(DRIFT_HALF)) >> 7);
      s3_neg_r[l]  <= s2_neg_r[l];
      s3_pos_r[l]  <= s2_pos_r[l];
      // reciprocal multiply in two partial products
      s4_pph_r[l]  <= 55'(s3_y_r[l][38:20]) * 55'(RECIP_M);
      s4_ppl_r[l]  <= 56'(s3_y_r[l][19:0]) * 56'(RECIP_M);
      s4_y_r[l]    <= s3_y_r[l];
      s4_neg_r[l]  <= s3_neg_r[l];
      s4_pos_r[l]  <= s3_pos_r[l];
      // quotient estimate, at most one short
      s5_q_r[l]    <= 23'((76'({s4_pph_r[l], 20'b0}) + 76'(s4_ppl_r[l])) >> 52);
      s5_y_r[l]    <= s4_y_r[l];
      s5_neg_r[l]  <= s4_neg_r[l];
      s5_pos_r[l]  <= s4_pos_r[l];
      s6_prod_r[l] <= 40'(s5_q_r[l]) * 40'(DRIFT_DIV);
      s6_q_r[l]    <= s5_q_r[l];
      s6_y_r[l]    <= s5_y_r[l];
      s6_neg_r[l]  <= s5_neg_r[l];
      s6_pos_r[l]  <= s5_pos_r[l];
      // correction and sign
      if (!s6_drift_r) begin
        s7_off_r[l] <= '0;
      end else if ((s6_y_r[l] - s6_prod_r[l][38:0]) >= 39'(DRIFT_DIV)) begin
        s7_off_r[l] <= s6_neg_r[l] ? -$signed({1'b0, s6_q_r[l] + 23'd1})
                                   :  $signed({1'b0, s6_q_r[l] + 23'd1});
      end else begin
        s7_off_r[l] <= s6_neg_r[l] ? -$signed({1'b0, s6_q_r[l]})
                                   :  $signed({1'b0, s6_q_r[l]});
      end
      s7_pos_r[l]  <= s6_pos_r[l];
    end
    s3_drift_r <= s2_drift_r;
    s4_drift_r <= s3_drift_r;
    s5_drift_r <= s4_drift_r;
    s6_drift_r <= s5_drift_r;
    s3_sh_r    <= s2_sh_r;
    s4_sh_r    <= s3_sh_r;
    s5_sh_r    <= s4_sh_r;
    s6_sh_r    <= s5_sh_r;
    s7_sh_r    <= s6_sh_r;
  end

  // stages 8..12: offset, rotation, rounding, squares
  always_ff @(posedge clk) begin
    for (int l = 0; l < 2; l++) begin
      s8_d_r[l] <= 26'(qpos[l]) - 26'(s7_pos_r[l]) - 26'(s7_off_r[l]);
    end
    s8_sh_r  <= s7_sh_r;
    s9_dnc_r <= 42'(s8_d_r[0]) * 42'(s8_sh_r.cos_q14);
    s9_des_r <= 42'(s8_d_r[1]) * 42'(s8_sh_r.sin_q14);
    s9_dns_r <= 42'(s8_d_r[0]) * 42'(s8_sh_r.sin_q14);
    s9_dec_r <= 42'(s8_d_r[1]) * 42'(s8_sh_r.cos_q14);
    s9_sh_r  <= s8_sh_r;
    s10_du_r <= 43'(s9_dnc_r) + 43'(s9_des_r);
    s10_dv_r <= 43'(s9_dec_r) - 43'(s9_dns_r);
    s10_sh_r <= s9_sh_r;
    s11_mag_r[0] <= round_mag(s10_du_r);
    s11_mag_r[1] <= round_mag(s10_dv_r);
    s11_sh_r <= s10_sh_r;
    for (int l = 0; l < 2; l++) begin
      s12_sq_r[l] <= 52'(s11_mag_r[l]) * 52'(s11_mag_r[l]);
    end
    s12_sh_r <= s11_sh_r;
  end

  // underflow test per axis
  always_comb begin
    s13_sh_nxt      = s12_sh_r;
    s13_sh_nxt.zero = s12_sh_r.zero ||
                      (s12_sq_r[0] >= 52'({s12_sh_r.rsq_u, 4'b0})) ||
                      (s12_sq_r[1] >= 52'({s12_sh_r.rsq_v, 4'b0}));
  end

  // stage 13: divider set-up
  always_ff @(posedge clk) begin
    s13_lane_r[0].rem <= s12_sq_r[0][34:4];
    s13_lane_r[0].den <= s12_sh_r.rsq_u;
    s13_lane_r[0].low <= s12_sq_r[0][3:0];
    s13_lane_r[0].quo <= '0;
    s13_lane_r[1].rem <= s12_sq_r[1][34:4];
    s13_lane_r[1].den <= s12_sh_r.rsq_v;
    s13_lane_r[1].low <= s12_sq_r[1][3:0];
    s13_lane_r[1].quo <= '0;
    s13_sh_r          <= s13_sh_nxt;
  end

  // divider: one quotient bit per stage and lane
  assign dl[0][0] = s13_lane_r[0];
  assign dl[0][1] = s13_lane_r[1];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    for (genvar l = 0; l < 2; l++) begin : g_lane
      ufml_div_step u_step (
        .clk      (clk),
        .in_lane  (dl[k][l]),
        .out_lane (dl[k+1][l])
      );
    end
  end

  always_ff @(posedge clk) begin
    dv_str_r[0]  <= s13_sh_r.strength;
    dv_zero_r[0] <= s13_sh_r.zero;
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_str_r[k]  <= dv_str_r[k-1];
      dv_zero_r[k] <= dv_zero_r[k-1];
    end
  end

  assign efrac = se_e_r[9:0];
  assign rr    = 20'(efrac) * 20'(efrac);

  // tail: exponent, table products, quadratic remainder, strength scale
  always_ff @(posedge clk) begin
    se_e_r    <= 21'(dl[DIV_STEPS][0].quo) + 21'(dl[DIV_STEPS][1].quo);
    se_str_r  <= dv_str_r[DIV_STEPS-1];
    se_zero_r <= dv_zero_r[DIV_STEPS-1];

    m1_prod_r <= 62'(EXP_I[se_e_r[19:16]]) * 62'(EXP_K[se_e_r[15:10]]);
    m1_p_r    <= EXP_ONE - 31'({efrac, 14'b0}) + 31'(rr >> 3);
    m1_str_r  <= se_str_r;
    m1_zero_r <= se_zero_r || se_e_r[20];

    m2_m_r    <= 31'((m1_prod_r + 62'(HALF_Q30)) >> 30);
    m2_p_r    <= m1_p_r;
    m2_str_r  <= m1_str_r;
    m2_zero_r <= m1_zero_r;

    m3_prod_r <= 62'(m2_m_r) * 62'(m2_p_r);
    m3_str_r  <= m2_str_r;
    m3_zero_r <= m2_zero_r;

    m4_m_r    <= 31'((m3_prod_r + 62'(HALF_Q30)) >> 30);
    m4_str_r  <= m3_str_r;
    m4_zero_r <= m3_zero_r;

    m5_prod_r <= 42'(m4_str_r) * 42'(m4_m_r);
    m5_zero_r <= m4_zero_r;

    m6_lift_r <= m5_zero_r ? '0 : 11'((m5_prod_r + 42'(HALF_Q30)) >> 30);
  end

  assign out_valid = vld_r[PIPE_LAT-1];
  assign out_lift  = m6_lift_r;

endmodule

/* sv/updraft_field_max_lift.sv */
// Updraft field top level: table, sweep sequencer and running maximum
// A load writes the table directly. A query strobes its result when the lifts
// of all n entries in use are back (none are read when n is 0): one entry a cycle
// through a 40-stage lift pipeline after a registered table read.
// busy is high from query accept until the result strobe; results cannot stall.
// Synchronous active-low reset clears entry_count and control; table is not.
`include "updraft_field_max_lift_defines.svh"
module updraft_field_max_lift #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_mode,
  input  logic [3:0]          in_slot,
  input  logic signed [20:0]  in_north_dm,
  input  logic signed [20:0]  in_east_dm,
  input  logic [10:0]         in_strength_cms,
  input  logic [11:0]         in_radius_along_m,
  input  logic [11:0]         in_radius_across_m,
  input  logic [8:0]          in_heading_deg,
  input  logic                in_drifts,
  input  logic [31:0]         in_time_us,
  input  logic signed [13:0]  in_wind_north_cms,
  input  logic signed [13:0]  in_wind_east_cms,
  output logic                out_valid,
  output logic [10:0]         out_lift_cms,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_entry_count
);
  import ufml_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [4:0]    entry_count_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [10:0]   best_r, best_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [10:0]   out_lift_r, out_lift_nxt;
  query_t        query_r;
  logic [CW-1:0] n_sat;
  logic          accept, wr_en, rd_en, finish;
  entry_t        wr_data;
  logic          tab_valid;
  entry_t        tab_data;
  logic          lift_valid;
  logic [10:0]   lift;

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign n_sat     = (32'(entry_count_r) > TABLE_DEPTH) ? CW'(TABLE_DEPTH)
                                                        : CW'(entry_count_r);

  // load requests write the table directly
  assign wr_en = accept && (in_mode == MODE_LOAD) && (32'(in_slot) < TABLE_DEPTH);
  always_comb begin
    wr_data.north_dm        = in_north_dm;
    wr_data.east_dm         = in_east_dm;
    wr_data.strength_cms    = in_strength_cms;
    wr_data.radius_along_m  = in_radius_along_m;
    wr_data.radius_across_m = in_radius_across_m;
    wr_data.heading_deg     = in_heading_deg;
    wr_data.drifts          = in_drifts;
    wr_data.created_us      = in_time_us;
  end

  assign rd_en  = (state_r == ST_RUN) && (idx_r < n_r);
  assign finish = (state_r == ST_RUN) && (cnt_r == n_r);

  ufml_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (AW'(in_slot)),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (idx_r[AW-1:0]),
    .rd_valid (tab_valid),
    .rd_data  (tab_data)
  );

  ufml_lift_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tab_valid),
    .in_entry  (tab_data),
    .query     (query_r),
    .out_valid (lift_valid),
    .out_lift  (lift)
  );

  // sweep sequencer and running maximum
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    best_nxt      = best_r;
    out_valid_nxt = 1'b0;
    out_lift_nxt  = out_lift_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && (in_mode == MODE_QUERY)) begin
          state_nxt = ST_RUN;
          n_nxt     = n_sat;
          idx_nxt   = '0;
          cnt_nxt   = '0;
          best_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (rd_en) idx_nxt = idx_r + 1'b1;
        if (lift_valid) begin
          cnt_nxt = cnt_r + 1'b1;
          if (lift > best_r) best_nxt = lift;
        end
        if (finish) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_lift_nxt  = best_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      entry_count_r <= '0;
      n_r           <= '0;
      idx_r         <= '0;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) entry_count_r <= cfg_entry_count;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_r     <= best_nxt;
    out_lift_r <= out_lift_nxt;
    if (accept && (in_mode == MODE_QUERY)) begin
      query_r.north_dm       <= in_north_dm;
      query_r.east_dm        <= in_east_dm;
      query_r.time_us        <= in_time_us;
      query_r.wind_north_cms <= in_wind_north_cms;
      query_r.wind_east_cms  <= in_wind_east_cms;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_lift_cms = out_lift_r;

  // checks
  `UFML_ASSERT(a_result_ends_sweep, out_valid |-> $past(busy))
  `UFML_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)
  `UFML_ASSERT(a_count_bounded, cnt_r <= n_r)
  `UFML_ASSERT_NEXT(a_load_silent, accept && (in_mode == MODE_LOAD), !out_valid)

endmodule
